[hw/rtl/pfw_pkg.sv]
// Shared types, register indexes, widths and fixed-point helpers for the pair force kernel.
package pfw_pkg;

   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 48;

   localparam logic [CSR_IDX_BITS-1:0] CSR_BOX_LENGTH   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LIST_RADIUS  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WELL_DEPTH   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CLASS_FIRST  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CLASS_SECOND = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CLASS_MIXED  = 3'd5;

   localparam logic [23:0] RESET_BOX   = 24'd4194304;
   localparam logic [23:0] RESET_LIST  = 24'd102400;
   localparam logic [23:0] RESET_EPS   = 24'd65536;
   localparam logic [47:0] RESET_CLASS = 48'd1099511710346;

   localparam int SIG_BITS  = 24;                 // sigma^2, cutoff^2, box
   localparam int AX_BITS   = 23;                 // |r| <= box/2
   localparam int D2_BITS   = 47;                 // ax^2 + ay^2
   localparam int T_SHIFT   = 48;
   localparam int DIV_STEPS = SIG_BITS + T_SHIFT; // quotient bits per divide

   typedef struct packed {
      logic [63:0] p00;
      logic [63:0] p01;
      logic [63:0] p10;
      logic [63:0] p11;
   } pp_type;

   // 32x32 partial products of a 64x64 product
   function automatic pp_type mul_pp(logic [63:0] a, logic [63:0] b);
      pp_type r;
      r.p00 = a[31:0] * b[31:0];
      r.p01 = a[31:0] * b[63:32];
      r.p10 = a[63:32] * b[31:0];
      r.p11 = a[63:32] * b[63:32];
      return r;
   endfunction

   // floor(a*b / 2^32), saturating
   function automatic logic [63:0] mul_sum(pp_type p);
      logic [63:0] mid;
      logic [63:0] hi;
      mid = {32'd0, p.p00[63:32]} + {32'd0, p.p01[31:0]} + {32'd0, p.p10[31:0]};
      hi = p.p11 + {32'd0, p.p01[63:32]} + {32'd0, p.p10[63:32]} + {32'd0, mid[63:32]};
      if (hi[63:32] != 32'd0) begin
         return '1;
      end
      return {hi[31:0], mid[31:0]};
   endfunction

   function automatic logic [63:0] sadd(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
   endfunction

endpackage

[hw/rtl/pair_force_wca_periodic.sv]
// Pair force kernel top level: minimum-image wrap, WCA energy and force, fully pipelined.
// Throughput one word per cycle outside reset; the result strobe rises once the word has
// passed COORD_BITS+89 register stages.
// Latency is set by the bit-serial wrap remainder (COORD_BITS stages), the 72-stage
// quotient pipeline for sigma^2/d2, ax/d2 and ay/d2, then 12 multiply stages.
// Synchronous reset clears all valid bits and loads register defaults; busy follows reset.
module pair_force_wca_periodic #(
   parameter int COORD_BITS = 24,
   parameter int FORCE_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [COORD_BITS-1:0]                 req_first_x,
   input  logic [COORD_BITS-1:0]                 req_first_y,
   input  logic [COORD_BITS-1:0]                 req_second_x,
   input  logic [COORD_BITS-1:0]                 req_second_y,
   input  logic                                  req_first_in_group_a,
   input  logic                                  req_second_in_group_a,
   output logic                                  rsp_valid,
   output logic                                  rsp_in_list,
   output logic signed [FORCE_BITS-1:0]          rsp_force_x,
   output logic signed [FORCE_BITS-1:0]          rsp_force_y,
   output logic signed [FORCE_BITS-1:0]          rsp_pair_energy,
   input  logic                                  csr_we,
   input  logic [pfw_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [pfw_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   localparam int CB   = COORD_BITS;
   localparam int SB   = pfw_pkg::SIG_BITS;
   localparam int AB   = pfw_pkg::AX_BITS;
   localparam int DW   = pfw_pkg::D2_BITS;
   localparam int TS   = pfw_pkg::T_SHIFT;
   localparam int DIVN = pfw_pkg::DIV_STEPS;
   localparam int NT   = 12;

   typedef struct packed {
      logic          vld;
      logic          ga;
      logic          gb;
      logic          sx;
      logic          sy;
      logic [CB-1:0] mx;
      logic [CB-1:0] my;
      logic [SB-1:0] rx;
      logic [SB-1:0] ry;
      logic          qx;
      logic          qy;
   } wrap_type;

   typedef struct packed {
      logic          vld;
      logic          nx;
      logic          ny;
      logic [AB-1:0] ax;
      logic [AB-1:0] ay;
      logic [SB-1:0] sig2;
      logic [SB-1:0] cut;
   } rnd_type;

   typedef struct packed {
      logic            vld;
      logic            nx;
      logic            ny;
      logic [AB-1:0]   ax;
      logic [AB-1:0]   ay;
      logic [SB-1:0]   sig2;
      logic [SB-1:0]   cut;
      logic [2*AB-1:0] sqx;
      logic [2*AB-1:0] sqy;
   } sq_type;

   typedef struct packed {
      logic          vld;
      logic          inl;
      logic          inc;
      logic          zero;
      logic          nx;
      logic          ny;
      logic [AB-1:0] ax;
      logic [AB-1:0] ay;
      logic [SB-1:0] sig2;
      logic [DW-1:0] d2;
      logic [DW-1:0] rt;
      logic [DW-1:0] rwx;
      logic [DW-1:0] rwy;
      logic [63:0]   qt;
      logic [63:0]   qwx;
      logic [63:0]   qwy;
      logic          ot;
   } div_type;

   typedef struct packed {
      logic           vld;
      logic           inl;
      logic           inc;
      logic           zero;
      logic           nx;
      logic           ny;
      logic           ge;
      logic           gneg;
      logic           eneg;
      logic [63:0]    t;
      logic [63:0]    wx;
      logic [63:0]    wy;
      logic [63:0]    m;
      logic [63:0]    u;
      logic [63:0]    u2;
      logic [63:0]    de;
      logic [63:0]    dbl;
      logic [63:0]    g;
      logic [63:0]    nm;
      logic [63:0]    f;
      logic [63:0]    e;
      logic [63:0]    fx;
      logic [63:0]    fy;
      pfw_pkg::pp_type ppa;
      pfw_pkg::pp_type ppb;
   } tail_type;

   // configuration
   logic [SB-1:0] box_ff, list_ff, eps_ff;
   logic [47:0]   cls_first_ff, cls_second_ff, cls_mixed_ff;
   logic [63:0]   eps_q_ff, eps4_ff, eps24_ff;
   logic [SB-1:0] box_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff        <= pfw_pkg::RESET_BOX;
         list_ff       <= pfw_pkg::RESET_LIST;
         eps_ff        <= pfw_pkg::RESET_EPS;
         cls_first_ff  <= pfw_pkg::RESET_CLASS;
         cls_second_ff <= pfw_pkg::RESET_CLASS;
         cls_mixed_ff  <= pfw_pkg::RESET_CLASS;
      end else if (csr_we) begin
         unique case (csr_index)
            pfw_pkg::CSR_BOX_LENGTH:   box_ff        <= csr_wdata[SB-1:0];
            pfw_pkg::CSR_LIST_RADIUS:  list_ff       <= csr_wdata[SB-1:0];
            pfw_pkg::CSR_WELL_DEPTH:   eps_ff        <= csr_wdata[SB-1:0];
            pfw_pkg::CSR_CLASS_FIRST:  cls_first_ff  <= csr_wdata;
            pfw_pkg::CSR_CLASS_SECOND: cls_second_ff <= csr_wdata;
            pfw_pkg::CSR_CLASS_MIXED:  cls_mixed_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // scaled epsilon, retimed from the register
   always_ff @(posedge clock) begin
      eps_q_ff <= {24'd0, eps_ff, 16'd0};
      eps4_ff  <= {22'd0, eps_ff, 18'd0};
      eps24_ff <= {20'd0, eps_ff, 20'd0} + {21'd0, eps_ff, 19'd0};
   end

   assign box_eff = (box_ff == '0) ? SB'(1) : box_ff;
   assign busy    = reset;

   // stage 0: separation magnitude and sign
   wrap_type wrap_ff [0:CB];
   wrap_type wrap_in [0:CB];
   logic [CB:0] dx, dy, ndx, ndy;

   always_comb begin
      dx  = {1'b0, req_second_x} - {1'b0, req_first_x};
      dy  = {1'b0, req_second_y} - {1'b0, req_first_y};
      ndx = ~dx + 1'b1;
      ndy = ~dy + 1'b1;
      wrap_in[0].vld = start && !busy;
      wrap_in[0].ga  = req_first_in_group_a && req_second_in_group_a;
      wrap_in[0].gb  = !req_first_in_group_a && !req_second_in_group_a;
      wrap_in[0].sx  = dx[CB];
      wrap_in[0].sy  = dy[CB];
      wrap_in[0].mx  = dx[CB] ? ndx[CB-1:0] : dx[CB-1:0];
      wrap_in[0].my  = dy[CB] ? ndy[CB-1:0] : dy[CB-1:0];
      wrap_in[0].rx  = '0;
      wrap_in[0].ry  = '0;
      wrap_in[0].qx  = 1'b0;
      wrap_in[0].qy  = 1'b0;
   end

   // remainder by box, one dividend bit per stage
   for (genvar i = 1; i <= CB; i++) begin : g_wrap
      logic [SB:0] trial_x, trial_y;
      always_comb begin
         wrap_in[i]    = wrap_ff[i-1];
         trial_x       = {wrap_ff[i-1].rx, wrap_ff[i-1].mx[CB-1]};
         trial_y       = {wrap_ff[i-1].ry, wrap_ff[i-1].my[CB-1]};
         wrap_in[i].mx = {wrap_ff[i-1].mx[CB-2:0], 1'b0};
         wrap_in[i].my = {wrap_ff[i-1].my[CB-2:0], 1'b0};
         wrap_in[i].qx = trial_x >= {1'b0, box_eff};
         wrap_in[i].qy = trial_y >= {1'b0, box_eff};
         wrap_in[i].rx = wrap_in[i].qx ? SB'(trial_x - {1'b0, box_eff}) : trial_x[SB-1:0];
         wrap_in[i].ry = wrap_in[i].qy ? SB'(trial_y - {1'b0, box_eff}) : trial_y[SB-1:0];
      end
   end

   for (genvar i = 0; i <= CB; i++) begin : g_wrap_ff
      always_ff @(posedge clock) begin
         if (reset) begin
            wrap_ff[i].vld <= 1'b0;
         end else begin
            wrap_ff[i] <= wrap_in[i];
         end
      end
   end

   // round to nearest image, ties to even; pick pair class
   rnd_type rnd_ff, rnd_in;
   logic [SB:0]   twice_x, twice_y;
   logic          up_x, up_y;
   logic [SB-1:0] ax_full, ay_full;
   logic [47:0]   cls_sel;

   always_comb begin
      twice_x = {wrap_ff[CB].rx, 1'b0};
      twice_y = {wrap_ff[CB].ry, 1'b0};
      up_x = (twice_x > {1'b0, box_eff}) || ((twice_x == {1'b0, box_eff}) && wrap_ff[CB].qx);
      up_y = (twice_y > {1'b0, box_eff}) || ((twice_y == {1'b0, box_eff}) && wrap_ff[CB].qy);
      ax_full = up_x ? box_eff - wrap_ff[CB].rx : wrap_ff[CB].rx;
      ay_full = up_y ? box_eff - wrap_ff[CB].ry : wrap_ff[CB].ry;
      priority if (wrap_ff[CB].ga) begin
         cls_sel = cls_first_ff;
      end else if (wrap_ff[CB].gb) begin
         cls_sel = cls_second_ff;
      end else begin
         cls_sel = cls_mixed_ff;
      end
      rnd_in.vld  = wrap_ff[CB].vld;
      rnd_in.nx   = wrap_ff[CB].sx ^ up_x;
      rnd_in.ny   = wrap_ff[CB].sy ^ up_y;
      rnd_in.ax   = ax_full[AB-1:0];
      rnd_in.ay   = ay_full[AB-1:0];
      rnd_in.sig2 = cls_sel[47:24];
      rnd_in.cut  = cls_sel[23:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_ff.vld <= 1'b0;
      end else begin
         rnd_ff <= rnd_in;
      end
   end

   // squares
   sq_type sq_ff, sq_in;

   always_comb begin
      sq_in.vld  = rnd_ff.vld;
      sq_in.nx   = rnd_ff.nx;
      sq_in.ny   = rnd_ff.ny;
      sq_in.ax   = rnd_ff.ax;
      sq_in.ay   = rnd_ff.ay;
      sq_in.sig2 = rnd_ff.sig2;
      sq_in.cut  = rnd_ff.cut;
      sq_in.sqx  = rnd_ff.ax * rnd_ff.ax;
      sq_in.sqy  = rnd_ff.ay * rnd_ff.ay;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ff.vld <= 1'b0;
      end else begin
         sq_ff <= sq_in;
      end
   end

   // d2, radius tests, then quotient pipelines
   div_type div_ff [0:DIVN];
   div_type div_in [0:DIVN];

   always_comb begin
      div_in[0]      = '0;
      div_in[0].vld  = sq_ff.vld;
      div_in[0].nx   = sq_ff.nx;
      div_in[0].ny   = sq_ff.ny;
      div_in[0].ax   = sq_ff.ax;
      div_in[0].ay   = sq_ff.ay;
      div_in[0].sig2 = sq_ff.sig2;
      div_in[0].d2   = {1'b0, sq_ff.sqx} + {1'b0, sq_ff.sqy};
      div_in[0].inl  = div_in[0].d2 <= {7'd0, list_ff, 16'd0};
      div_in[0].inc  = div_in[0].d2 <= {7'd0, sq_ff.cut, 16'd0};
      div_in[0].zero = div_in[0].d2 == '0;
   end

   for (genvar k = 1; k <= DIVN; k++) begin : g_div
      localparam int P = DIVN - k;
      logic        nb_t, nb_x, nb_y;
      logic [DW:0] trial_t, trial_x, trial_y;
      logic        ge_t, ge_x, ge_y;

      if (P >= TS) begin : g_nt
         assign nb_t = div_ff[k-1].sig2[P-TS];
      end else begin : g_nt0
         assign nb_t = 1'b0;
      end
      if (P >= TS && P < TS + AB) begin : g_nw
         assign nb_x = div_ff[k-1].ax[P-TS];
         assign nb_y = div_ff[k-1].ay[P-TS];
      end else begin : g_nw0
         assign nb_x = 1'b0;
         assign nb_y = 1'b0;
      end

      always_comb begin
         div_in[k]     = div_ff[k-1];
         trial_t       = {div_ff[k-1].rt, nb_t};
         trial_x       = {div_ff[k-1].rwx, nb_x};
         trial_y       = {div_ff[k-1].rwy, nb_y};
         ge_t          = trial_t >= {1'b0, div_ff[k-1].d2};
         ge_x          = trial_x >= {1'b0, div_ff[k-1].d2};
         ge_y          = trial_y >= {1'b0, div_ff[k-1].d2};
         div_in[k].rt  = ge_t ? DW'(trial_t - {1'b0, div_ff[k-1].d2}) : trial_t[DW-1:0];
         div_in[k].rwx = ge_x ? DW'(trial_x - {1'b0, div_ff[k-1].d2}) : trial_x[DW-1:0];
         div_in[k].rwy = ge_y ? DW'(trial_y - {1'b0, div_ff[k-1].d2}) : trial_y[DW-1:0];
         div_in[k].qt  = {div_ff[k-1].qt[62:0], ge_t};
         div_in[k].qwx = {div_ff[k-1].qwx[62:0], ge_x};
         div_in[k].qwy = {div_ff[k-1].qwy[62:0], ge_y};
         div_in[k].ot  = div_ff[k-1].ot | div_ff[k-1].qt[63];
      end
   end

   for (genvar k = 0; k <= DIVN; k++) begin : g_div_ff
      always_ff @(posedge clock) begin
         if (reset) begin
            div_ff[k].vld <= 1'b0;
         end else begin
            div_ff[k] <= div_in[k];
         end
      end
   end

   // multiply tail
   tail_type tl_ff [1:NT];
   tail_type tl_in [1:NT];

   always_comb begin
      tl_in[1]      = '0;
      tl_in[1].vld  = div_ff[DIVN].vld;
      tl_in[1].inl  = div_ff[DIVN].inl;
      tl_in[1].inc  = div_ff[DIVN].inc;
      tl_in[1].zero = div_ff[DIVN].zero;
      tl_in[1].nx   = div_ff[DIVN].nx;
      tl_in[1].ny   = div_ff[DIVN].ny;
      tl_in[1].t    = div_ff[DIVN].ot ? '1 : div_ff[DIVN].qt;
      tl_in[1].wx   = div_ff[DIVN].qwx;
      tl_in[1].wy   = div_ff[DIVN].qwy;
      tl_in[1].ppa  = pfw_pkg::mul_pp(tl_in[1].t, tl_in[1].t);

      tl_in[2]      = tl_ff[1];
      tl_in[2].m    = pfw_pkg::mul_sum(tl_ff[1].ppa);

      tl_in[3]      = tl_ff[2];
      tl_in[3].ppa  = pfw_pkg::mul_pp(tl_ff[2].m, tl_ff[2].t);

      tl_in[4]      = tl_ff[3];
      tl_in[4].u    = pfw_pkg::mul_sum(tl_ff[3].ppa);

      tl_in[5]      = tl_ff[4];
      tl_in[5].ppa  = pfw_pkg::mul_pp(tl_ff[4].u, tl_ff[4].u);

      tl_in[6]      = tl_ff[5];
      tl_in[6].u2   = pfw_pkg::mul_sum(tl_ff[5].ppa);

      tl_in[7]      = tl_ff[6];
      tl_in[7].ge   = tl_ff[6].u2 >= tl_ff[6].u;
      tl_in[7].de   = tl_in[7].ge ? tl_ff[6].u2 - tl_ff[6].u : tl_ff[6].u - tl_ff[6].u2;
      tl_in[7].dbl  = tl_ff[6].u2[63] ? '1 : {tl_ff[6].u2[62:0], 1'b0};

      tl_in[8]      = tl_ff[7];
      tl_in[8].gneg = tl_ff[7].dbl < tl_ff[7].u;
      tl_in[8].g    = tl_in[8].gneg ? tl_ff[7].u - tl_ff[7].dbl : tl_ff[7].dbl - tl_ff[7].u;
      tl_in[8].ppa  = pfw_pkg::mul_pp(eps4_ff, tl_ff[7].de);

      tl_in[9]      = tl_ff[8];
      tl_in[9].nm   = pfw_pkg::mul_sum(tl_ff[8].ppa);
      tl_in[9].ppb  = pfw_pkg::mul_pp(eps24_ff, tl_ff[8].g);

      tl_in[10]     = tl_ff[9];
      tl_in[10].f   = pfw_pkg::mul_sum(tl_ff[9].ppb);
      if (tl_ff[9].ge) begin
         tl_in[10].eneg = 1'b0;
         tl_in[10].e    = pfw_pkg::sadd(tl_ff[9].nm, eps_q_ff);
      end else begin
         tl_in[10].eneg = tl_ff[9].nm > eps_q_ff;
         tl_in[10].e    = tl_in[10].eneg ? tl_ff[9].nm - eps_q_ff : eps_q_ff - tl_ff[9].nm;
      end

      tl_in[11]     = tl_ff[10];
      tl_in[11].ppa = pfw_pkg::mul_pp(tl_ff[10].f, tl_ff[10].wx);
      tl_in[11].ppb = pfw_pkg::mul_pp(tl_ff[10].f, tl_ff[10].wy);

      tl_in[12]     = tl_ff[11];
      tl_in[12].fx  = pfw_pkg::mul_sum(tl_ff[11].ppa);
      tl_in[12].fy  = pfw_pkg::mul_sum(tl_ff[11].ppb);
   end

   for (genvar s = 1; s <= NT; s++) begin : g_tail_ff
      always_ff @(posedge clock) begin
         if (reset) begin
            tl_ff[s].vld <= 1'b0;
         end else begin
            tl_ff[s] <= tl_in[s];
         end
      end
   end

   // Q32.32 magnitude with sign to saturated signed Q16.16
   function automatic logic [FORCE_BITS-1:0] to_out(logic [63:0] mag, logic neg);
      logic [47:0] v;
      logic [47:0] lim;
      v   = mag[63:16];
      lim = 48'd1 << (FORCE_BITS - 1);
      if (neg) begin
         if (v > lim) begin
            v = lim;
         end
         v = ~v + 48'd1;
      end else if (v > lim - 48'd1) begin
         v = lim - 48'd1;
      end
      return v[FORCE_BITS-1:0];
   endfunction

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_in_list_ff, rsp_in_list_in;
   logic [FORCE_BITS-1:0] force_x_ff, force_x_in;
   logic [FORCE_BITS-1:0] force_y_ff, force_y_in;
   logic [FORCE_BITS-1:0] energy_ff, energy_in;

   always_comb begin
      rsp_valid_in   = tl_ff[NT].vld;
      rsp_in_list_in = tl_ff[NT].vld && tl_ff[NT].inl;
      priority if (!tl_ff[NT].vld || !tl_ff[NT].inl || !tl_ff[NT].inc) begin
         force_x_in = '0;
         force_y_in = '0;
         energy_in  = '0;
      end else if (tl_ff[NT].zero) begin
         force_x_in = '0;
         force_y_in = '0;
         energy_in  = to_out('1, 1'b0);
      end else begin
         force_x_in = to_out(tl_ff[NT].fx, tl_ff[NT].gneg ^ tl_ff[NT].nx);
         force_y_in = to_out(tl_ff[NT].fy, tl_ff[NT].gneg ^ tl_ff[NT].ny);
         energy_in  = to_out(tl_ff[NT].e, tl_ff[NT].eneg);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         rsp_in_list_ff <= 1'b0;
      end else begin
         rsp_valid_ff   <= rsp_valid_in;
         rsp_in_list_ff <= rsp_in_list_in;
      end
      force_x_ff <= force_x_in;
      force_y_ff <= force_y_in;
      energy_ff  <= energy_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_in_list     = rsp_in_list_ff;
   assign rsp_force_x     = force_x_ff;
   assign rsp_force_y     = force_y_ff;
   assign rsp_pair_energy = energy_ff;

endmodule

[hw/rtl/pfw_check.sv]
// Port-level checks for the pair force kernel, bound to the top level.
module pfw_check #(
   parameter int LATENCY    = 113,
   parameter int FORCE_BITS = 32
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         rsp_valid,
   input logic                         rsp_in_list,
   input logic signed [FORCE_BITS-1:0] rsp_force_x,
   input logic signed [FORCE_BITS-1:0] rsp_force_y,
   input logic signed [FORCE_BITS-1:0] rsp_pair_energy
);

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result word without matching accepted word");

   a_out_of_list: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_list |->
         rsp_force_x == '0 && rsp_force_y == '0 && rsp_pair_energy == '0)
      else $error("non-zero result outside list radius");

   a_flag_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !rsp_in_list)
      else $error("in_list set without strobe");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("strobe right after reset");

endmodule

bind pair_force_wca_periodic pfw_check #(
   .LATENCY    (COORD_BITS + 89),
   .FORCE_BITS (FORCE_BITS)
) u_pfw_check (.*);

[tb/sv/tb_pair_force_wca_periodic.sv]
// Self-checking testbench for the WCA pair force kernel: directed table, then random pairs.
module tb_pair_force_wca_periodic;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 600000;
   localparam int DRAIN_CYCLES = 120;
   localparam int PHASES = 8;
   localparam int WORDS_PER_PHASE = 240;

   typedef struct packed {
      logic [23:0] first_x;
      logic [23:0] first_y;
      logic [23:0] second_x;
      logic [23:0] second_y;
      logic        first_a;
      logic        second_a;
   } pair_req_type;

   typedef struct packed {
      logic        in_list;
      logic [31:0] force_x;
      logic [31:0] force_y;
      logic [31:0] energy;
   } pair_result_type;

   typedef struct packed {
      pair_req_type    req;
      logic            typed;
      pair_result_type res;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [23:0] req_first_x = '0, req_first_y = '0, req_second_x = '0, req_second_y = '0;
   logic req_first_in_group_a = 1'b0, req_second_in_group_a = 1'b0;
   logic rsp_valid, rsp_in_list;
   logic signed [31:0] rsp_force_x, rsp_force_y, rsp_pair_energy;
   logic csr_we = 1'b0;
   logic [pfw_pkg::CSR_IDX_BITS-1:0] csr_index = '0;
   logic [pfw_pkg::CSR_DATA_BITS-1:0] csr_wdata = '0;

   logic [23:0] cfg_box, cfg_list, cfg_eps;
   logic [47:0] cfg_first, cfg_second, cfg_mixed;

   pair_result_type pending_q[$];
   bit failed = 0;
   int unsigned cycles = 0;
   dir_row_type dir_rows[12];
   bit no_gaps;

   pair_force_wca_periodic DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_first_x(req_first_x), .req_first_y(req_first_y),
      .req_second_x(req_second_x), .req_second_y(req_second_y),
      .req_first_in_group_a(req_first_in_group_a),
      .req_second_in_group_a(req_second_in_group_a),
      .rsp_valid(rsp_valid), .rsp_in_list(rsp_in_list),
      .rsp_force_x(rsp_force_x), .rsp_force_y(rsp_force_y),
      .rsp_pair_energy(rsp_pair_energy),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic logic [63:0] q_mul(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = ({64'd0, a} * {64'd0, b}) >> 32;
      return (p[127:64] != 0) ? '1 : p[63:0];
   endfunction

   function automatic logic [63:0] div_shift(logic [63:0] n, logic [63:0] d);
      logic [127:0] q;
      q = ({64'd0, n} << 48) / {64'd0, d};
      return (q[127:64] != 0) ? '1 : q[63:0];
   endfunction

   function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
   endfunction

   function automatic logic [31:0] to_q16(logic [63:0] mag, bit neg);
      logic [63:0] v;
      v = mag >> 16;
      if (neg) begin
         if (v > 64'h8000_0000) v = 64'h8000_0000;
         return 32'(64'd0 - v);
      end
      if (v > 64'h7FFF_FFFF) v = 64'h7FFF_FFFF;
      return v[31:0];
   endfunction

   // nearest image of b - a, ties to even multiple of the box
   function automatic longint min_image(logic [23:0] a, logic [23:0] b, logic [63:0] box);
      longint diff, r;
      logic [63:0] mag, n, rem;
      diff = longint'({40'd0, b}) - longint'({40'd0, a});
      mag = diff < 0 ? -diff : diff;
      n = mag / box;
      rem = mag % box;
      if (2 * rem > box || (2 * rem == box && n[0])) n++;
      r = longint'(mag) - longint'(n * box);
      return diff < 0 ? -r : r;
   endfunction

   function automatic pair_result_type pair_force(pair_req_type q);
      logic [63:0] box, ax, ay, d2, p, sig2, cut, eps, t, u, u2, e, nm, dbl, g, f;
      longint rx, ry;
      bit eneg, gneg;
      pair_result_type r;
      r = '0;
      box = (cfg_box == 0) ? 64'd1 : {40'd0, cfg_box};
      rx = min_image(q.first_x, q.second_x, box);
      ry = min_image(q.first_y, q.second_y, box);
      ax = rx < 0 ? -rx : rx;
      ay = ry < 0 ? -ry : ry;
      d2 = ax * ax + ay * ay;
      if (d2 > ({40'd0, cfg_list} << 16)) return r;
      r.in_list = 1'b1;
      p = (q.first_a && q.second_a) ? cfg_first :
          ((!q.first_a && !q.second_a) ? cfg_second : cfg_mixed);
      sig2 = p[47:24];
      cut = p[23:0];
      if (d2 > (cut << 16)) return r;
      if (d2 == 0) begin
         r.energy = to_q16('1, 0);
         return r;
      end
      eps = {40'd0, cfg_eps} << 16;
      t = div_shift(sig2, d2);
      u = q_mul(q_mul(t, t), t);
      u2 = q_mul(u, u);
      if (u2 >= u) begin
         e = add_sat(q_mul(4 * eps, u2 - u), eps);
         eneg = 0;
      end else begin
         nm = q_mul(4 * eps, u - u2);
         eneg = nm > eps;
         e = eneg ? nm - eps : eps - nm;
      end
      r.energy = to_q16(e, eneg);
      dbl = add_sat(u2, u2);
      gneg = dbl < u;
      g = gneg ? u - dbl : dbl - u;
      f = q_mul(24 * eps, g);
      r.force_x = to_q16(q_mul(f, div_shift(ax, d2)), gneg != (rx < 0));
      r.force_y = to_q16(q_mul(f, div_shift(ay, d2)), gneg != (ry < 0));
      return r;
   endfunction

   task automatic send_word(pair_req_type q, bit typed, pair_result_type res, int gap);
      req_first_x <= q.first_x;
      req_first_y <= q.first_y;
      req_second_x <= q.second_x;
      req_second_y <= q.second_y;
      req_first_in_group_a <= q.first_a;
      req_second_in_group_a <= q.second_a;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      pending_q.push_back(typed ? res : pair_force(q));
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // write enable is dropped by the caller once the sequence of writes is done
   task automatic csr_write(logic [pfw_pkg::CSR_IDX_BITS-1:0] idx, logic [47:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         pfw_pkg::CSR_BOX_LENGTH:   cfg_box = val[23:0];
         pfw_pkg::CSR_LIST_RADIUS:  cfg_list = val[23:0];
         pfw_pkg::CSR_WELL_DEPTH:   cfg_eps = val[23:0];
         pfw_pkg::CSR_CLASS_FIRST:  cfg_first = val;
         pfw_pkg::CSR_CLASS_SECOND: cfg_second = val;
         pfw_pkg::CSR_CLASS_MIXED:  cfg_mixed = val;
         default: ;
      endcase
   endtask

   task automatic drain;
      start <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [23:0] rand24();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return 24'd1 << $urandom_range(0, 23);
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [23:0] near(logic [23:0] base, int unsigned span);
      logic [23:0] off;
      off = 24'($urandom_range(0, span));
      if ($urandom_range(0, 3) == 0) off = off + 24'(cfg_box * $urandom_range(0, 4));
      return $urandom_range(0, 1) ? base + off : base - off;
   endfunction

   function automatic pair_req_type rand_pair();
      pair_req_type q;
      int unsigned span;
      q.first_x = 24'($urandom);
      q.first_y = 24'($urandom);
      q.first_a = 1'($urandom_range(0, 1));
      q.second_a = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 4))
         0: span = 8;
         1: span = 1 << 12;
         2: span = 1 << 20;
         default: span = 100000;
      endcase
      if ($urandom_range(0, 9) < 8) begin
         q.second_x = near(q.first_x, span);
         q.second_y = near(q.first_y, span);
      end else begin
         q.second_x = 24'($urandom);
         q.second_y = 24'($urandom);
      end
      return q;
   endfunction

   always @(posedge clock) begin
      pair_result_type x;
      if (!reset && rsp_valid) begin
         if (pending_q.size() == 0) begin
            $error("unexpected result word");
            failed = 1;
         end else begin
            x = pending_q.pop_front();
            if (rsp_in_list !== x.in_list) begin
               $error("in_list: expected %0d, got %0d", x.in_list, rsp_in_list);
               failed = 1;
            end
            if (rsp_force_x !== x.force_x) begin
               $error("force_x: expected %h, got %h", x.force_x, rsp_force_x);
               failed = 1;
            end
            if (rsp_force_y !== x.force_y) begin
               $error("force_y: expected %h, got %h", x.force_y, rsp_force_y);
               failed = 1;
            end
            if (rsp_pair_energy !== x.energy) begin
               $error("pair_energy: expected %h, got %h", x.energy, rsp_pair_energy);
               failed = 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      pair_result_type none;
      none = '0;
      cfg_box = pfw_pkg::RESET_BOX;
      cfg_list = pfw_pkg::RESET_LIST;
      cfg_eps = pfw_pkg::RESET_EPS;
      cfg_first = pfw_pkg::RESET_CLASS;
      cfg_second = pfw_pkg::RESET_CLASS;
      cfg_mixed = pfw_pkg::RESET_CLASS;
      no_gaps = 0;

      // coincident pair: energy pinned at max, no direction
      dir_rows[0] = '{'{24'd0, 24'd0, 24'd0, 24'd0, 1'b1, 1'b1}, 1'b1,
                      '{1'b1, 32'd0, 32'd0, 32'h7FFF_FFFF}};
      // exactly half a box apart: tie keeps the even image, far outside
      dir_rows[1] = '{'{24'd0, 24'd0, 24'd2097152, 24'd0, 1'b0, 1'b0}, 1'b1, none};
      // three half boxes: tie rounds up to the even multiple
      dir_rows[2] = '{'{24'd0, 24'd0, 24'd6291456, 24'd0, 1'b0, 1'b1}, 1'b1, none};
      dir_rows[3] = '{'{24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'd0, 1'b1, 1'b1}, 1'b0, none};
      dir_rows[4] = '{'{24'd0, 24'd0, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 1'b0}, 1'b0, none};
      dir_rows[5] = '{'{24'd100, 24'd100, 24'd65636, 24'd100, 1'b1, 1'b1}, 1'b0, none};
      dir_rows[6] = '{'{24'd100, 24'd100, 24'd100, 24'd65636, 1'b0, 1'b0}, 1'b0, none};
      dir_rows[7] = '{'{24'd70000, 24'd5000, 24'd5000, 24'd70000, 1'b1, 1'b0}, 1'b0, none};
      dir_rows[8] = '{'{24'd0, 24'd0, 24'd70000, 24'd0, 1'b0, 1'b1}, 1'b0, none};
      dir_rows[9] = '{'{24'd0, 24'd0, 24'd75000, 24'd0, 1'b1, 1'b1}, 1'b0, none};
      dir_rows[10] = '{'{24'h123456, 24'h3FFFFF, 24'h123457, 24'h400000, 1'b0, 1'b0},
                       1'b0, none};
      dir_rows[11] = '{'{24'd0, 24'd0, 24'd4194304, 24'd8388608, 1'b1, 1'b0}, 1'b1,
                       '{1'b1, 32'd0, 32'd0, 32'h7FFF_FFFF}};

      reset <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) send_word(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res,
                                      pick_gap());

      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         case (ph)
            0: begin
               csr_write(pfw_pkg::CSR_BOX_LENGTH, 48'hFFFFFF);
               csr_write(pfw_pkg::CSR_LIST_RADIUS, 48'hFFFFFF);
               csr_write(pfw_pkg::CSR_WELL_DEPTH, 48'hFFFFFF);
               csr_write(pfw_pkg::CSR_CLASS_FIRST, '1);
               csr_write(pfw_pkg::CSR_CLASS_SECOND, '1);
               csr_write(pfw_pkg::CSR_CLASS_MIXED, '1);
            end
            1: begin
               csr_write(pfw_pkg::CSR_BOX_LENGTH, 48'd0);
               csr_write(pfw_pkg::CSR_LIST_RADIUS, 48'd0);
               csr_write(pfw_pkg::CSR_WELL_DEPTH, 48'd0);
               csr_write(pfw_pkg::CSR_CLASS_FIRST, 48'd0);
               csr_write(pfw_pkg::CSR_CLASS_SECOND, 48'd0);
               csr_write(pfw_pkg::CSR_CLASS_MIXED, 48'd0);
            end
            2: begin
               csr_write(pfw_pkg::CSR_BOX_LENGTH, 48'd1);
               csr_write(pfw_pkg::CSR_LIST_RADIUS, 48'hFFFFFF);
               csr_write(pfw_pkg::CSR_WELL_DEPTH, 48'd65536);
            end
            default: begin
               csr_write(pfw_pkg::CSR_BOX_LENGTH, {24'd0, $urandom_range(0, 3) == 0 ?
                         rand24() : 24'($urandom_range(1 << 16, 1 << 23))});
               csr_write(pfw_pkg::CSR_LIST_RADIUS, {24'd0, rand24()});
               csr_write(pfw_pkg::CSR_WELL_DEPTH, {24'd0, rand24()});
               csr_write(pfw_pkg::CSR_CLASS_FIRST, {rand24(), rand24()});
               csr_write(pfw_pkg::CSR_CLASS_SECOND,
                         {24'($urandom_range(0, 1 << 18)), rand24()});
               csr_write(pfw_pkg::CSR_CLASS_MIXED, {rand24(), 24'($urandom)});
            end
         endcase
         csr_we <= 1'b0;
         no_gaps = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            if (n % 60 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            send_word(rand_pair(), 1'b0, none, pick_gap());
         end
      end

      start <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!failed) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

[pair_force_wca_periodic.f]
hw/rtl/pfw_pkg.sv
hw/rtl/pair_force_wca_periodic.sv
hw/rtl/pfw_check.sv
tb/sv/tb_pair_force_wca_periodic.sv
